// ----- rtl/bba_pkg.sv -----
// Shared types, widths and constants of the bouncing ball animator.
package bba_pkg;

  // Default screen size in pixels.
  localparam int unsigned SCREEN_WIDTH_DEF  = 800;
  localparam int unsigned SCREEN_HEIGHT_DEF = 480;

  // Field widths.
  localparam int unsigned POS_X_W   = 14;
  localparam int unsigned POS_Y_W   = 13;
  localparam int unsigned RADIUS_W  = 12;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned TETHER_W  = 4;
  localparam int unsigned SPEED_W   = 9;
  localparam int unsigned CENTRE_W  = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DW    = 12;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X_SPEED = 3'd0,
    REG_START_Y_SPEED = 3'd1,
    REG_RADIUS_STEP   = 3'd2,
    REG_MIN_RADIUS    = 3'd3,
    REG_MAX_RADIUS    = 3'd4,
    REG_ALPHA_FLOOR   = 3'd5
  } cfg_reg_e;

  // Register reset values.
  localparam logic signed [SPEED_W-1:0] START_X_SPEED_RST = 9'sd48;
  localparam logic signed [SPEED_W-1:0] START_Y_SPEED_RST = -9'sd32;
  localparam logic [7:0]                RADIUS_STEP_RST   = 8'd16;
  localparam logic [RADIUS_W-1:0]       MIN_RADIUS_RST    = 12'd160;
  localparam logic [RADIUS_W-1:0]       MAX_RADIUS_RST    = 12'd3520;
  localparam logic [COLOR_W-1:0]        ALPHA_FLOOR_RST   = 8'd128;

  // Values loaded into the ball state at reset and restart, and the top of the alpha ramp.
  localparam logic [RADIUS_W-1:0] SIZE_INIT  = 12'd50;
  localparam logic [COLOR_W-1:0]  RED_INIT   = 8'hff;
  localparam logic [COLOR_W-1:0]  GREEN_INIT = 8'h00;
  localparam logic [COLOR_W-1:0]  BLUE_INIT  = 8'h80;
  localparam logic [COLOR_W-1:0]  ALPHA_INIT = 8'h00;
  localparam logic [COLOR_W-1:0]  ALPHA_TOP  = 8'hff;

  localparam logic [RADIUS_W-1:0] RADIUS_MAX = 12'd4095;
  localparam logic [TETHER_W-1:0] TETHER_MAX = 4'd10;
  localparam logic [TETHER_W-1:0] TETHER_MIN = 4'd1;

endpackage

// ----- rtl/bouncing_ball_animator.sv -----
// Top level of the bouncing ball animator: ball state, frame update and result stage.
//
//   channel  direction  handshake                  payload
//   in       request    in_valid_i / in_ready_o    restart_i
//   out      result     out_valid_o / out_ready_i  pos_x_o pos_y_o radius_o red_o green_o
//                                                  blue_o alpha_o tether_width_o
//   cfg      write      cfg_we_i                   cfg_idx_i cfg_data_i
//
// One request is accepted per cycle while in_ready_o is high. The state registers take
// the updated ball state, and the output register then takes the saturated
// position and tether width.
// A stalled output holds; the state stage still takes one more request behind it.
// Reset loads the register defaults and the initial ball; no clearing pass.
module bouncing_ball_animator import bba_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 restart_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [POS_X_W-1:0]   pos_x_o,
  output logic [POS_Y_W-1:0]   pos_y_o,
  output logic [RADIUS_W-1:0]  radius_o,
  output logic [COLOR_W-1:0]   red_o,
  output logic [COLOR_W-1:0]   green_o,
  output logic [COLOR_W-1:0]   blue_o,
  output logic [COLOR_W-1:0]   alpha_o,
  output logic [TETHER_W-1:0]  tether_width_o
);

  localparam int unsigned X_LIMIT  = SCREEN_WIDTH * 16;
  localparam int unsigned Y_LIMIT  = SCREEN_HEIGHT * 16;
  localparam int unsigned HALF_W   = SCREEN_WIDTH / 2;
  localparam int unsigned HALF_H   = SCREEN_HEIGHT / 2;
  localparam int unsigned HALF_SUM = HALF_W + HALF_H;
  localparam logic signed [CENTRE_W-1:0] X_INIT = CENTRE_W'(HALF_W * 16);
  localparam logic signed [CENTRE_W-1:0] Y_INIT = CENTRE_W'(HALF_H * 16);
  localparam logic signed [16:0] X_MAX = 17'(X_LIMIT - 1);
  localparam logic signed [16:0] Y_MAX = 17'(Y_LIMIT - 1);
  localparam int unsigned Q_STEPS = 11;

  // Configuration registers.
  logic signed [SPEED_W-1:0] start_x_q, start_y_q;
  logic [7:0]                step_q;
  logic [RADIUS_W-1:0]       min_rad_q, max_rad_q;
  logic [COLOR_W-1:0]        floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= START_X_SPEED_RST;
      start_y_q <= START_Y_SPEED_RST;
      step_q    <= RADIUS_STEP_RST;
      min_rad_q <= MIN_RADIUS_RST;
      max_rad_q <= MAX_RADIUS_RST;
      floor_q   <= ALPHA_FLOOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_X_SPEED: start_x_q <= cfg_data_i[SPEED_W-1:0];
        REG_START_Y_SPEED: start_y_q <= cfg_data_i[SPEED_W-1:0];
        REG_RADIUS_STEP:   step_q    <= cfg_data_i[7:0];
        REG_MIN_RADIUS:    min_rad_q <= cfg_data_i[RADIUS_W-1:0];
        REG_MAX_RADIUS:    max_rad_q <= cfg_data_i[RADIUS_W-1:0];
        REG_ALPHA_FLOOR:   floor_q   <= cfg_data_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Ball state.
  logic signed [CENTRE_W-1:0] cx_q, cx_d, cy_q, cy_d, cx_adv, cy_adv;
  logic signed [SPEED_W-1:0]  vx_q, vx_d, vy_q, vy_d, vx_adv, vy_adv;
  logic signed [SPEED_W-1:0]  dsize_q, dsize_d, dsize_adv;
  logic [RADIUS_W-1:0]        size_q, size_d, size_adv;
  logic [COLOR_W-1:0]         r_q, r_d, g_q, g_d, b_q, b_d, a_q, a_d, a_adv;
  logic                       rising_q, rising_d, rising_adv;

  // Radius step with reflection at either bound.
  logic signed [13:0] s_sum;
  logic signed [14:0] s_nxt;
  logic               s_bounce;

  always_comb begin
    s_sum = $signed({2'b00, size_q}) + 14'(dsize_q);
    if (dsize_q < 0) begin
      s_bounce = !($signed({2'b00, min_rad_q}) < s_sum);
      s_nxt    = s_bounce ? $signed({2'b00, min_rad_q, 1'b0}) - 15'(s_sum) : 15'(s_sum);
    end else begin
      s_bounce = !(s_sum < $signed({2'b00, max_rad_q}));
      s_nxt    = s_bounce ? $signed({2'b00, max_rad_q, 1'b0}) - 15'(s_sum) : 15'(s_sum);
    end
    if (s_nxt < 0) begin
      size_adv = '0;
    end else if (s_nxt > $signed({3'b000, RADIUS_MAX})) begin
      size_adv = RADIUS_MAX;
    end else begin
      size_adv = s_nxt[RADIUS_W-1:0];
    end
    dsize_adv = s_bounce ? -dsize_q : dsize_q;
  end

  // Alpha ramps to full and back down to the floor.
  always_comb begin
    a_adv      = a_q;
    rising_adv = rising_q;
    if (rising_q) begin
      if (a_q != ALPHA_TOP) begin
        a_adv = a_q + 8'd1;
      end else begin
        rising_adv = 1'b0;
      end
    end else begin
      if (floor_q < a_q) begin
        a_adv = a_q - 8'd1;
      end else begin
        rising_adv = 1'b1;
      end
    end
  end

  // Motion uses the radius of the current frame.
  bba_axis #(.LIMIT(X_LIMIT)) u_axis_x (
    .pos_i (cx_q),
    .vel_i (vx_q),
    .rad_i (size_adv),
    .pos_o (cx_adv),
    .vel_o (vx_adv)
  );

  bba_axis #(.LIMIT(Y_LIMIT)) u_axis_y (
    .pos_i (cy_q),
    .vel_i (vy_q),
    .rad_i (size_adv),
    .pos_o (cy_adv),
    .vel_o (vy_adv)
  );

  always_comb begin
    if (restart_i) begin
      cx_d     = X_INIT;
      cy_d     = Y_INIT;
      vx_d     = start_x_q;
      vy_d     = start_y_q;
      size_d   = SIZE_INIT;
      dsize_d  = $signed({1'b0, step_q});
      r_d      = RED_INIT;
      g_d      = GREEN_INIT;
      b_d      = BLUE_INIT;
      a_d      = ALPHA_INIT;
      rising_d = 1'b1;
    end else begin
      cx_d     = cx_adv;
      cy_d     = cy_adv;
      vx_d     = vx_adv;
      vy_d     = vy_adv;
      size_d   = size_adv;
      dsize_d  = dsize_adv;
      r_d      = r_q + 8'd1;
      g_d      = g_q - 8'd1;
      b_d      = b_q + 8'd2;
      a_d      = a_adv;
      rising_d = rising_adv;
    end
  end

  // Handshake: the state registers form the first stage, the result registers the second.
  logic s1_valid_q, out_valid_q, out_en, s1_en, accept;

  assign out_en     = !out_valid_q || out_ready_i;
  assign s1_en      = !s1_valid_q || out_en;
  assign accept     = in_valid_i && s1_en;
  assign in_ready_o = s1_en;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q        <= X_INIT;
      cy_q        <= Y_INIT;
      vx_q        <= START_X_SPEED_RST;
      vy_q        <= START_Y_SPEED_RST;
      size_q      <= SIZE_INIT;
      dsize_q     <= $signed({1'b0, RADIUS_STEP_RST});
      r_q         <= RED_INIT;
      g_q         <= GREEN_INIT;
      b_q         <= BLUE_INIT;
      a_q         <= ALPHA_INIT;
      rising_q    <= 1'b1;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cx_q     <= cx_d;
        cy_q     <= cy_d;
        vx_q     <= vx_d;
        vy_q     <= vy_d;
        size_q   <= size_d;
        dsize_q  <= dsize_d;
        r_q      <= r_d;
        g_q      <= g_d;
        b_q      <= b_d;
        a_q      <= a_d;
        rising_q <= rising_d;
      end
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Saturated position and tether width from the Manhattan distance to the centre.
  logic signed [16:0]  cx_e, cy_e;
  logic [14:0]         px, py;
  logic signed [11:0]  dx_s, dy_s;
  logic [10:0]         dx, dy;
  logic [11:0]         mdist;
  logic [15:0]         dist10;
  logic [Q_STEPS-1:0]  hit;
  logic [TETHER_W-1:0] q, tw;

  always_comb begin
    cx_e = 17'(cx_q);
    cy_e = 17'(cy_q);
    if (cx_e < 0) begin
      px = '0;
    end else if (cx_e > X_MAX) begin
      px = X_MAX[14:0];
    end else begin
      px = cx_e[14:0];
    end
    if (cy_e < 0) begin
      py = '0;
    end else if (cy_e > Y_MAX) begin
      py = Y_MAX[14:0];
    end else begin
      py = cy_e[14:0];
    end
    dx_s   = $signed({1'b0, px[14:4]}) - 12'(HALF_W);
    dy_s   = $signed({1'b0, py[14:4]}) - 12'(HALF_H);
    dx     = dx_s < 0 ? 11'(-dx_s) : dx_s[10:0];
    dy     = dy_s < 0 ? 11'(-dy_s) : dy_s[10:0];
    mdist  = {1'b0, dx} + {1'b0, dy};
    dist10 = 16'(mdist) * 16'd10;
    // The quotient by the half-screen sum is the count of multiples reached.
    for (int k = 0; k < Q_STEPS; k++) begin
      hit[k] = dist10 >= 16'((k + 1) * HALF_SUM);
    end
    q  = TETHER_W'($countones(hit));
    tw = (q > TETHER_MAX) ? TETHER_MIN : TETHER_MAX - q;
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s1_valid_q) begin
      pos_x_o        <= px[POS_X_W-1:0];
      pos_y_o        <= py[POS_Y_W-1:0];
      radius_o       <= size_q;
      red_o          <= r_q;
      green_o        <= g_q;
      blue_o         <= b_q;
      alpha_o        <= a_q;
      tether_width_o <= tw;
    end
  end

endmodule

// ----- rtl/bba_axis.sv -----
// One axis of ball motion: step the centre and reflect it off the inset screen edges.
module bba_axis import bba_pkg::*; #(
  parameter int unsigned LIMIT = SCREEN_WIDTH_DEF * 16
) (
  input  logic signed [CENTRE_W-1:0] pos_i,
  input  logic signed [SPEED_W-1:0]  vel_i,
  input  logic        [RADIUS_W-1:0] rad_i,
  output logic signed [CENTRE_W-1:0] pos_o,
  output logic signed [SPEED_W-1:0]  vel_o
);

  localparam logic signed [18:0] LIM = 19'(LIMIT);
  localparam logic signed [18:0] POS_HI = 19'sd32767;
  localparam logic signed [18:0] POS_LO = -19'sd32768;
  localparam logic signed [SPEED_W-1:0] VEL_MIN = -9'sd256;
  localparam logic signed [SPEED_W-1:0] VEL_MAX = 9'sd255;

  logic signed [18:0] p, v, r, pv, nxt;
  logic               bounce;

  always_comb begin
    p  = 19'(pos_i);
    v  = 19'(vel_i);
    r  = $signed({7'b0, rad_i});
    pv = p + v;
    if (vel_i < 0) begin
      bounce = !(pv - r > 0);
      nxt    = bounce ? (r <<< 1) - pv : pv;
    end else begin
      bounce = !(pv + r < LIM);
      nxt    = bounce ? ((LIM - r) <<< 1) - pv : pv;
    end
    if (nxt > POS_HI) begin
      pos_o = POS_HI[CENTRE_W-1:0];
    end else if (nxt < POS_LO) begin
      pos_o = POS_LO[CENTRE_W-1:0];
    end else begin
      pos_o = nxt[CENTRE_W-1:0];
    end
    // The most negative speed has no positive twin, so it flips to the largest one.
    if (!bounce) begin
      vel_o = vel_i;
    end else if (vel_i == VEL_MIN) begin
      vel_o = VEL_MAX;
    end else begin
      vel_o = -vel_i;
    end
  end

endmodule

// ----- rtl/bba_checker.sv -----
// Port-level checks for the bouncing ball animator and their binding.
module bba_checker import bba_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [POS_X_W-1:0]  pos_x_o,
  input logic [POS_Y_W-1:0]  pos_y_o,
  input logic [TETHER_W-1:0] tether_width_o
);

  localparam int unsigned X_LIMIT = SCREEN_WIDTH * 16;
  localparam int unsigned Y_LIMIT = SCREEN_HEIGHT * 16;

  // A result that waits is held until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(pos_x_o) && $stable(pos_y_o) && $stable(tether_width_o))
    else $error("stalled result changed");

  // With the output register empty there is always room for a request.
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("request refused with empty output");

  a_pos_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(pos_x_o) < X_LIMIT)
    else $error("x position off screen");

  a_pos_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(pos_y_o) < Y_LIMIT)
    else $error("y position off screen");

  a_tether: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tether_width_o <= TETHER_MAX)
    else $error("tether width out of range");

endmodule

bind bouncing_ball_animator bba_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_bba_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .pos_x_o        (pos_x_o),
  .pos_y_o        (pos_y_o),
  .tether_width_o (tether_width_o)
);

// ----- sim/bba_frame_checker.sv -----
// Frame checker for the bouncing ball animator: tracks registers, predicts and compares frames.
module bba_frame_checker import bba_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 restart_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [POS_X_W-1:0]   pos_x_i,
  input  logic [POS_Y_W-1:0]   pos_y_i,
  input  logic [RADIUS_W-1:0]  radius_i,
  input  logic [COLOR_W-1:0]   red_i,
  input  logic [COLOR_W-1:0]   green_i,
  input  logic [COLOR_W-1:0]   blue_i,
  input  logic [COLOR_W-1:0]   alpha_i,
  input  logic [TETHER_W-1:0]  tether_width_i,
  output int unsigned          frames_waiting_o,
  output int unsigned          mismatches_o
);

  typedef struct packed {
    logic [POS_X_W-1:0]  pos_x;
    logic [POS_Y_W-1:0]  pos_y;
    logic [RADIUS_W-1:0] radius;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
    logic [COLOR_W-1:0]  alpha;
    logic [TETHER_W-1:0] tether;
  } ball_frame_t;

  localparam int XLIM      = int'(SCREEN_WIDTH) * 16;
  localparam int YLIM      = int'(SCREEN_HEIGHT) * 16;
  localparam int HALF_SPAN = int'(SCREEN_WIDTH) / 2 + int'(SCREEN_HEIGHT) / 2;

  // Register copies.
  logic signed [SPEED_W-1:0] vx0_q, vy0_q;
  logic [7:0]                rstep_q;
  logic [RADIUS_W-1:0]       rmin_q, rmax_q;
  logic [COLOR_W-1:0]        floor_q;

  // Ball state.
  logic signed [CENTRE_W-1:0] ctr_x_q, ctr_y_q;
  logic signed [SPEED_W-1:0]  vel_x_q, vel_y_q;
  logic [RADIUS_W:0]          size_q;
  logic signed [SPEED_W-1:0]  size_step_q;
  logic [COLOR_W-1:0]         red_q, green_q, blue_q, alpha_q;
  logic                       alpha_up_q;

  ball_frame_t pending_frames[$];
  int unsigned n_bad;

  function automatic int clip(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Negating the most negative speed would not fit, so it turns into the largest positive one.
  function automatic int turn_speed(input int v);
    return (v <= -256) ? 255 : -v;
  endfunction

  task automatic reload_ball();
    ctr_x_q     = CENTRE_W'(int'(SCREEN_WIDTH) / 2 * 16);
    ctr_y_q     = CENTRE_W'(int'(SCREEN_HEIGHT) / 2 * 16);
    vel_x_q     = vx0_q;
    vel_y_q     = vy0_q;
    size_q      = {1'b0, SIZE_INIT};
    size_step_q = $signed({1'b0, rstep_q});
    red_q       = RED_INIT;
    green_q     = GREEN_INIT;
    blue_q      = BLUE_INIT;
    alpha_q     = ALPHA_INIT;
    alpha_up_q  = 1'b1;
  endtask

  // Moves one axis and reflects it off the edges inset by the current radius.
  task automatic bounce_axis(inout int p, inout int v, input int lim);
    int r;
    r = int'(size_q);
    if (v < 0) begin
      if (p - r + v > 0) begin
        p = p + v;
      end else begin
        p = 2 * r - (p + v);
        v = turn_speed(v);
      end
    end else begin
      if (p + r + v < lim) begin
        p = p + v;
      end else begin
        p = 2 * (lim - r) - (p + v);
        v = turn_speed(v);
      end
    end
    p = clip(p, -32768, 32767);
  endtask

  task automatic advance_ball();
    int s, sz, lo, hi, p, v;
    red_q   = red_q + 8'd1;
    green_q = green_q - 8'd1;
    blue_q  = blue_q + 8'd2;
    if (alpha_up_q) begin
      if (alpha_q != ALPHA_TOP) alpha_q = alpha_q + 8'd1;
      else alpha_up_q = 1'b0;
    end else begin
      if (floor_q < alpha_q) alpha_q = alpha_q - 8'd1;
      else alpha_up_q = 1'b1;
    end

    lo = int'(rmin_q);
    hi = int'(rmax_q);
    s  = int'(size_q) + int'(size_step_q);
    if (size_step_q < 0) begin
      if (lo < s) begin
        sz = s;
      end else begin
        sz = 2 * lo - s;
        size_step_q = -size_step_q;
      end
    end else begin
      if (s < hi) begin
        sz = s;
      end else begin
        sz = 2 * hi - s;
        size_step_q = -size_step_q;
      end
    end
    size_q = (RADIUS_W+1)'(clip(sz, 0, int'(RADIUS_MAX)));

    p = int'(ctr_x_q);
    v = int'(vel_x_q);
    bounce_axis(p, v, XLIM);
    ctr_x_q = CENTRE_W'(p);
    vel_x_q = SPEED_W'(v);

    p = int'(ctr_y_q);
    v = int'(vel_y_q);
    bounce_axis(p, v, YLIM);
    ctr_y_q = CENTRE_W'(p);
    vel_y_q = SPEED_W'(v);
  endtask

  function automatic ball_frame_t frame_of_ball();
    ball_frame_t f;
    int px, py, dx, dy, w;
    px = clip(int'(ctr_x_q), 0, XLIM - 1);
    py = clip(int'(ctr_y_q), 0, YLIM - 1);
    dx = px / 16 - int'(SCREEN_WIDTH) / 2;
    if (dx < 0) dx = -dx;
    dy = py / 16 - int'(SCREEN_HEIGHT) / 2;
    if (dy < 0) dy = -dy;
    w = int'(TETHER_MAX) - (10 * (dx + dy)) / HALF_SPAN;
    if (w < 0) w = int'(TETHER_MIN);
    f.pos_x  = POS_X_W'(px);
    f.pos_y  = POS_Y_W'(py);
    f.radius = RADIUS_W'(size_q);
    f.red    = red_q;
    f.green  = green_q;
    f.blue   = blue_q;
    f.alpha  = alpha_q;
    f.tether = TETHER_W'(w);
    return f;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_bad++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    ball_frame_t want;
    if (!rst_ni) begin
      vx0_q   = START_X_SPEED_RST;
      vy0_q   = START_Y_SPEED_RST;
      rstep_q = RADIUS_STEP_RST;
      rmin_q  = MIN_RADIUS_RST;
      rmax_q  = MAX_RADIUS_RST;
      floor_q = ALPHA_FLOOR_RST;
      reload_ball();
      pending_frames.delete();
      n_bad = 0;
    end else begin
      // A result is matched before the request of this edge is predicted.
      if (out_valid_i && out_ready_i) begin
        if (pending_frames.size() == 0) begin
          $error("frame result with no request outstanding");
          n_bad++;
        end else begin
          want = pending_frames.pop_front();
          check_field("pos_x", 16'(want.pos_x), 16'(pos_x_i));
          check_field("pos_y", 16'(want.pos_y), 16'(pos_y_i));
          check_field("radius", 16'(want.radius), 16'(radius_i));
          check_field("red", 16'(want.red), 16'(red_i));
          check_field("green", 16'(want.green), 16'(green_i));
          check_field("blue", 16'(want.blue), 16'(blue_i));
          check_field("alpha", 16'(want.alpha), 16'(alpha_i));
          check_field("tether_width", 16'(want.tether), 16'(tether_width_i));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_START_X_SPEED: vx0_q   = $signed(cfg_data_i[SPEED_W-1:0]);
          REG_START_Y_SPEED: vy0_q   = $signed(cfg_data_i[SPEED_W-1:0]);
          REG_RADIUS_STEP:   rstep_q = cfg_data_i[7:0];
          REG_MIN_RADIUS:    rmin_q  = cfg_data_i[RADIUS_W-1:0];
          REG_MAX_RADIUS:    rmax_q  = cfg_data_i[RADIUS_W-1:0];
          REG_ALPHA_FLOOR:   floor_q = cfg_data_i[COLOR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (restart_i) reload_ball();
        else advance_ball();
        pending_frames.push_back(frame_of_ball());
      end
    end
    frames_waiting_o <= pending_frames.size();
    mismatches_o     <= n_bad;
  end

endmodule

// ----- sim/tb_bouncing_ball_animator.sv -----
// Testbench top for the bouncing ball animator: clock, reset, stimulus and verdict.
module tb_bouncing_ball_animator;
  import bba_pkg::*;

  localparam int unsigned SCR_W = SCREEN_WIDTH_DEF;
  localparam int unsigned SCR_H = SCREEN_HEIGHT_DEF;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_PHASES    = 7;
  localparam int FRAMES_PER_PHASE = 232;
  localparam int HOLD_CYCLES      = 300;
  localparam int PRESSURE_PHASE   = 2;

  // Indexes with no register behind them; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_DW-1:0]    cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 restart_i   = 1'b0;
  logic                 out_ready_i = 1'b0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [POS_X_W-1:0]   pos_x_o;
  logic [POS_Y_W-1:0]   pos_y_o;
  logic [RADIUS_W-1:0]  radius_o;
  logic [COLOR_W-1:0]   red_o, green_o, blue_o, alpha_o;
  logic [TETHER_W-1:0]  tether_width_o;

  int unsigned frames_waiting;
  int unsigned mismatches;
  bit          gaps_on = 1'b1;
  bit          hold_now = 1'b0;

  bouncing_ball_animator #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .restart_i,
    .out_valid_o, .out_ready_i,
    .pos_x_o, .pos_y_o, .radius_o, .red_o, .green_o, .blue_o, .alpha_o, .tether_width_o
  );

  bba_frame_checker #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .restart_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .pos_x_i(pos_x_o), .pos_y_i(pos_y_o), .radius_i(radius_o),
    .red_i(red_o), .green_i(green_o), .blue_i(blue_o), .alpha_i(alpha_o),
    .tether_width_i(tether_width_o),
    .frames_waiting_o(frames_waiting),
    .mismatches_o(mismatches)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_bouncing_ball_animator: errors");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off so the block backs up.
  initial begin : result_sink
    int stall;
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_now && !held) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        held = 1'b1;
        out_ready_i <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall = $urandom_range(1, 19);
        repeat (stall) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic write_setting(input logic [CFG_DW-1:0] vx, input logic [CFG_DW-1:0] vy,
                               input logic [CFG_DW-1:0] step, input logic [CFG_DW-1:0] rmin,
                               input logic [CFG_DW-1:0] rmax, input logic [CFG_DW-1:0] floor_v);
    write_reg(REG_START_X_SPEED, vx);
    write_reg(REG_START_Y_SPEED, vy);
    write_reg(REG_RADIUS_STEP, step);
    write_reg(REG_MIN_RADIUS, rmin);
    write_reg(REG_MAX_RADIUS, rmax);
    write_reg(REG_ALPHA_FLOOR, floor_v);
    cfg_we_i <= 1'b0;
  endtask

  // Valid stays high from one request to the next unless a gap is inserted.
  task automatic send_frame(input logic restart);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frames_waiting != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Two frames straight out of reset with the default registers.
    send_frame(1'b0);
    send_frame(1'b0);
    drain_results();

    // Fastest negative speeds and a fast-growing radius: both axes hit the low edge
    // within a few frames, and the most negative speed has to turn around.
    write_reg(REG_UNUSED_LO, '1);
    write_reg(REG_UNUSED_HI, '1);
    write_setting(12'h100, 12'h100, 12'd255, 12'd0, 12'd4095, 12'd255);
    send_frame(1'b1);
    repeat (20) send_frame(1'b0);
    send_frame(1'b1);
    drain_results();

    for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
      case (phase)
        1: write_setting(12'h0ff, 12'h0ff, 12'd255, 12'd4095, 12'd4095, 12'd255);
        2: write_setting(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        3: write_setting(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                         12'($urandom_range(0, 4095)), 12'($urandom_range(2048, 4095)),
                         12'($urandom_range(0, 2047)), 12'($urandom_range(0, 4095)));
        default: write_setting(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                               12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                               12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      endcase
      if (phase == PRESSURE_PHASE) hold_now = 1'b1;
      if (phase == RANDOM_PHASES) gaps_on = 1'b0;
      send_frame(1'b1);
      repeat (FRAMES_PER_PHASE) send_frame($urandom_range(0, 40) == 0);
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) $display("tb_bouncing_ball_animator: clean");
    else $display("tb_bouncing_ball_animator: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/bba_pkg.sv
rtl/bba_axis.sv
rtl/bouncing_ball_animator.sv
rtl/bba_checker.sv
sim/bba_frame_checker.sv
sim/tb_bouncing_ball_animator.sv
